/* hw/rtl/qac_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qac_pkg
// Shared types and constants for the quaternary autocorrelation pair update.
// ----------------------------------------------------------------------------
package qac_pkg;

  localparam int unsigned CorrW = 8;
  localparam int unsigned ScoreW = 20;
  localparam logic [ScoreW-1:0] ScoreMax = 20'hFFFFF;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init;     // write the reset contents at the shift counter and advance
    logic load;     // capture the item
    logic rd_old;   // read the old phases at both positions
    logic delta;    // latch the phase differences
    logic upd_a;    // read the correlation and the neighbors of the first position
    logic upd_b;    // fold in the first position, read neighbors of the second
    logic upd_c;    // fold in the second position, write the correlation, advance
    logic commit0;  // write the first new phase
    logic commit1;  // write the second new phase
    logic score;    // read both correlations at the shift counter and advance
    logic clr;      // clear accumulator and shift counter
  } cmd_t;

  typedef struct packed {
    logic last;     // shift counter at its final value
  } sts_t;

  function automatic logic signed [1:0] root_re(input logic [1:0] p);
    case (p)
      2'd0: root_re = 2'sd1;
      2'd2: root_re = -2'sd1;
      default: root_re = 2'sd0;
    endcase
  endfunction

  function automatic logic signed [1:0] root_im(input logic [1:0] p);
    case (p)
      2'd1: root_im = 2'sd1;
      2'd3: root_im = -2'sd1;
      default: root_im = 2'sd0;
    endcase
  endfunction

endpackage

/* hw/rtl/qac_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qac_ctrl
// Sequencer: clearing pass, update pass over all shifts, score pass, output.
// ----------------------------------------------------------------------------
module qac_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          reject_i,
  input  logic          out_free_i,
  output logic          in_ready_o,
  output logic          out_load_o,
  input  qac_pkg::sts_t sts_i,
  output qac_pkg::cmd_t cmd_o
);

  localparam logic [3:0] StInit = 4'd0;
  localparam logic [3:0] StIdle = 4'd1;
  localparam logic [3:0] StOld = 4'd2;
  localparam logic [3:0] StDelta = 4'd3;
  localparam logic [3:0] StUpdA = 4'd4;
  localparam logic [3:0] StUpdB = 4'd5;
  localparam logic [3:0] StUpdC = 4'd6;
  localparam logic [3:0] StCommit0 = 4'd7;
  localparam logic [3:0] StCommit1 = 4'd8;
  localparam logic [3:0] StScore = 4'd9;
  localparam logic [3:0] StDrain = 4'd10;
  localparam logic [3:0] StOut = 4'd11;

  logic [3:0] state_q, state_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    out_load_o = 1'b0;
    case (state_q)
      StInit: begin
        cmd_o.init = 1'b1;
        if (sts_i.last) state_d = StIdle;
      end
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cmd_o.clr = 1'b1;
          state_d = reject_i ? StScore : StOld;
        end
      end
      StOld: begin
        cmd_o.rd_old = 1'b1;
        state_d = StDelta;
      end
      StDelta: begin
        cmd_o.delta = 1'b1;
        state_d = StUpdA;
      end
      StUpdA: begin
        cmd_o.upd_a = 1'b1;
        state_d = StUpdB;
      end
      StUpdB: begin
        cmd_o.upd_b = 1'b1;
        state_d = StUpdC;
      end
      StUpdC: begin
        cmd_o.upd_c = 1'b1;
        state_d = sts_i.last ? StCommit0 : StUpdA;
      end
      StCommit0: begin
        cmd_o.commit0 = 1'b1;
        state_d = StCommit1;
      end
      StCommit1: begin
        cmd_o.commit1 = 1'b1;
        state_d = StScore;
      end
      StScore: begin
        cmd_o.score = 1'b1;
        if (sts_i.last) state_d = StDrain;
      end
      StDrain: begin
        state_d = StOut;
      end
      StOut: begin
        if (out_free_i) begin
          out_load_o = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StInit;
    else state_q <= state_d;
  end

endmodule

/* hw/rtl/qac_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qac_dp
// Phase and correlation storage, per-shift update and score accumulator.
// ----------------------------------------------------------------------------
module qac_dp #(
  parameter int unsigned SeqLen = 42
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  qac_pkg::cmd_t             cmd_i,
  output qac_pkg::sts_t             sts_o,
  input  logic                      sel_i,
  input  logic [5:0]                p0_i,
  input  logic [1:0]                n0_i,
  input  logic [5:0]                p1_i,
  input  logic [1:0]                n1_i,
  output logic                      reject_o,
  output logic [qac_pkg::ScoreW-1:0] score_o
);

  localparam int unsigned IdxW = $clog2(SeqLen);
  localparam int unsigned CW = qac_pkg::CorrW;

  logic [IdxW-1:0] s_q;
  logic            sel_q;
  logic [IdxW-1:0] p_q [2];
  logic [1:0]      n_q [2];
  logic signed [2:0] dre_q [2], dim_q [2];
  logic signed [CW-1:0] dacc_re_q, dacc_im_q;
  logic            sc_v_q;
  logic [IdxW-1:0] sc_s_q;
  logic [35:0]     acc_q;

  // Memory ports. Each sequence has its own phase and correlation memory.
  logic            ph_re;
  logic [IdxW-1:0] ph_ra, ph_rb, ph_wa;
  logic [1:0]      ph_we;
  logic [1:0]      ph_wd;
  logic [1:0]      ph_a [2];
  logic [1:0]      ph_b [2];
  logic            corr_re;
  logic [1:0]      corr_we;
  logic [2*CW-1:0] corr_wd;
  logic [2*CW-1:0] corr_rd [2];

  assign reject_o = (p0_i == p1_i) || ({26'd0, p0_i} >= SeqLen) ||
                    ({26'd0, p1_i} >= SeqLen);
  assign sts_o.last = ({{(32-IdxW){1'b0}}, s_q} == SeqLen - 1);

  function automatic logic [IdxW-1:0] wrap(input logic [IdxW:0] v);
    logic [IdxW:0] w;
    w = v - (IdxW+1)'(SeqLen);
    wrap = (v >= (IdxW+1)'(SeqLen)) ? w[IdxW-1:0] : v[IdxW-1:0];
  endfunction

  // Contribution of one changed position at the current shift, packed {im, re}.
  function automatic logic [2*CW-1:0] fold(input logic signed [2:0] d_re,
                                           input logic signed [2:0] d_im,
                                           input logic [1:0] xf,
                                           input logic [1:0] xb);
    logic signed [CW-1:0] er, ei, xr, xi, yr, yi, fr, fi;
    er = CW'(d_re);
    ei = CW'(d_im);
    xr = CW'(qac_pkg::root_re(xf));
    xi = CW'(qac_pkg::root_im(xf));
    yr = CW'(qac_pkg::root_re(xb));
    yi = CW'(qac_pkg::root_im(xb));
    fr = er*xr + ei*xi + yr*er + yi*ei;
    fi = ei*xr - er*xi + yi*er - yr*ei;
    fold = {fi, fr};
  endfunction

  // Neighbor addresses of both changed positions at the current shift.
  logic [IdxW-1:0] fwd [2], bck [2];
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      fwd[a] = wrap({1'b0, p_q[a]} + {1'b0, s_q});
      bck[a] = wrap({1'b0, p_q[a]} + (IdxW+1)'(SeqLen) - {1'b0, s_q});
    end
  end

  // Port control.
  always_comb begin
    ph_re = cmd_i.rd_old || cmd_i.upd_a || cmd_i.upd_b;
    if (cmd_i.rd_old) begin
      ph_ra = p_q[0];
      ph_rb = p_q[1];
    end else if (cmd_i.upd_b) begin
      ph_ra = fwd[1];
      ph_rb = bck[1];
    end else begin
      ph_ra = fwd[0];
      ph_rb = bck[0];
    end
    ph_we = 2'b00;
    ph_wa = s_q;
    ph_wd = 2'd0;
    if (cmd_i.init) begin
      ph_we = 2'b11;
    end else if (cmd_i.commit0 || cmd_i.commit1) begin
      ph_we = sel_q ? 2'b10 : 2'b01;
      ph_wa = cmd_i.commit1 ? p_q[1] : p_q[0];
      ph_wd = cmd_i.commit1 ? n_q[1] : n_q[0];
    end
    corr_re = cmd_i.upd_a || cmd_i.score;
  end

  // Correlation update for the current shift.
  logic [2*CW-1:0] part;
  logic signed [CW-1:0] cross_re, cross_im, new_re, new_im;
  always_comb begin
    logic signed [CW-1:0] ar, ai, br, bi;
    part = cmd_i.upd_c ? fold(dre_q[1], dim_q[1], ph_a[sel_q], ph_b[sel_q])
                       : fold(dre_q[0], dim_q[0], ph_a[sel_q], ph_b[sel_q]);
    cross_re = '0;
    cross_im = '0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        ar = CW'(dre_q[a]);
        ai = CW'(dim_q[a]);
        br = CW'(dre_q[b]);
        bi = CW'(dim_q[b]);
        if (fwd[a] == p_q[b]) begin
          cross_re = cross_re + ar*br + ai*bi;
          cross_im = cross_im + ai*br - ar*bi;
        end
      end
    end
    new_re = $signed(corr_rd[sel_q][CW-1:0]) + dacc_re_q + $signed(part[CW-1:0]) +
             cross_re;
    new_im = $signed(corr_rd[sel_q][2*CW-1:CW]) + dacc_im_q +
             $signed(part[2*CW-1:CW]) + cross_im;
    if (cmd_i.init) begin
      corr_we = 2'b11;
      corr_wd = {CW'(0), CW'(SeqLen)};
    end else begin
      corr_we = cmd_i.upd_c ? (sel_q ? 2'b10 : 2'b01) : 2'b00;
      corr_wd = {new_im, new_re};
    end
  end

  // Score term for the shift whose correlations were read last cycle.
  logic signed [CW+1:0] dr, di;
  logic [23:0] term;
  always_comb begin
    logic signed [CW+1:0] t;
    logic signed [23:0] dw_re, dw_im;
    case ({{(32-IdxW){1'b0}}, sc_s_q})
      32'd4, 32'd11, 32'd31, 32'd38: t = -(CW+2)'(4);
      32'd10, 32'd17, 32'd25, 32'd32: t = '0;
      default: t = -(CW+2)'(2);
    endcase
    dr = (CW+2)'($signed(corr_rd[0][CW-1:0])) + (CW+2)'($signed(corr_rd[1][CW-1:0])) - t;
    di = (CW+2)'($signed(corr_rd[0][2*CW-1:CW])) +
         (CW+2)'($signed(corr_rd[1][2*CW-1:CW]));
    dw_re = 24'(dr);
    dw_im = 24'(di);
    term = $unsigned(dw_re*dw_re) + $unsigned(dw_im*dw_im);
  end

  // Memories with registered read data.
  for (genvar q = 0; q < 2; q++) begin : g_seq
    logic [1:0]      ph_mem [SeqLen];
    logic [2*CW-1:0] corr_mem [SeqLen];
    logic [1:0]      ph_a_q, ph_b_q;
    logic [2*CW-1:0] corr_q;

    always_ff @(posedge clk_i) begin
      if (ph_we[q]) ph_mem[ph_wa] <= ph_wd;
      if (ph_re) begin
        ph_a_q <= ph_mem[ph_ra];
        ph_b_q <= ph_mem[ph_rb];
      end
      if (corr_we[q]) corr_mem[s_q] <= corr_wd;
      if (corr_re) corr_q <= corr_mem[s_q];
    end

    assign ph_a[q] = ph_a_q;
    assign ph_b[q] = ph_b_q;
    assign corr_rd[q] = corr_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sel_q <= sel_i;
      p_q[0] <= p0_i[IdxW-1:0];
      p_q[1] <= p1_i[IdxW-1:0];
      n_q[0] <= n0_i;
      n_q[1] <= n1_i;
    end
    if (cmd_i.delta) begin
      dre_q[0] <= 3'(qac_pkg::root_re(n_q[0])) - 3'(qac_pkg::root_re(ph_a[sel_q]));
      dim_q[0] <= 3'(qac_pkg::root_im(n_q[0])) - 3'(qac_pkg::root_im(ph_a[sel_q]));
      dre_q[1] <= 3'(qac_pkg::root_re(n_q[1])) - 3'(qac_pkg::root_re(ph_b[sel_q]));
      dim_q[1] <= 3'(qac_pkg::root_im(n_q[1])) - 3'(qac_pkg::root_im(ph_b[sel_q]));
    end
    if (cmd_i.upd_b) begin
      dacc_re_q <= $signed(part[CW-1:0]);
      dacc_im_q <= $signed(part[2*CW-1:CW]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      acc_q <= '0;
      sc_v_q <= 1'b0;
      sc_s_q <= '0;
    end else begin
      sc_v_q <= cmd_i.score;
      sc_s_q <= s_q;
      if (cmd_i.clr) begin
        s_q <= '0;
      end else if (cmd_i.init || cmd_i.upd_c || cmd_i.score) begin
        s_q <= sts_o.last ? '0 : s_q + 1'b1;
      end
      if (cmd_i.clr) acc_q <= '0;
      else if (sc_v_q && sc_s_q != '0) acc_q <= acc_q + 36'(term);
    end
  end

  assign score_o = (acc_q > 36'(qac_pkg::ScoreMax)) ? qac_pkg::ScoreMax
                                                    : acc_q[qac_pkg::ScoreW-1:0];

endmodule

/* hw/rtl/quaternary_autocorr_pair_update_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternary_autocorr_pair_update_top
// Two quaternary sequences with incremental periodic autocorrelation update
// and a residual score against a fixed target.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  s_axis  | in  | tdata: seq_sel, pos_first, phase_first, pos_second, phase_second
//  m_axis  | out | tdata: residual_score; tuser: rejected
//
// After reset a clearing pass writes phase 0 and correlation SEQ_LEN into every
// entry while s_axis_tready stays low. An accepted item then reads the old
// phases and latches their differences, updates every shift in the states
// UpdA, UpdB and UpdC, writes the two new phases, scores every shift, drains
// and loads the output. A rejected item skips to the score pass. A result
// stalled on m_axis holds the next item off.
module quaternary_autocorr_pair_update_top #(
  parameter int unsigned SEQ_LEN = 42
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] seq_sel, [6:1] pos_first, [8:7] phase_first, [14:9] pos_second,
  // [16:15] phase_second, [23:17] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [19:0] residual_score, [23:20] zero
  output logic [23:0] m_axis_tdata,
  // [0] rejected
  output logic        m_axis_tuser
);

  qac_pkg::cmd_t cmd;
  qac_pkg::sts_t sts;
  logic reject, out_load;
  logic [qac_pkg::ScoreW-1:0] score;
  logic rej_q;
  logic [qac_pkg::ScoreW-1:0] score_q;
  logic vld_q;

  qac_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(s_axis_tvalid), .reject_i(reject),
    .out_free_i(!vld_q || m_axis_tready),
    .in_ready_o(s_axis_tready), .out_load_o(out_load),
    .sts_i(sts), .cmd_o(cmd)
  );

  qac_dp #(.SeqLen(SEQ_LEN)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .sts_o(sts),
    .sel_i(s_axis_tdata[0]), .p0_i(s_axis_tdata[6:1]), .n0_i(s_axis_tdata[8:7]),
    .p1_i(s_axis_tdata[14:9]), .n1_i(s_axis_tdata[16:15]),
    .reject_o(reject), .score_o(score)
  );

  // Reject flag is captured with the item and held until the result leaves.
  logic rej_hold_q;
  always_ff @(posedge clk_i) begin
    if (cmd.load) rej_hold_q <= reject;
    if (out_load) begin
      score_q <= score;
      rej_q <= rej_hold_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= 1'b0;
    else if (out_load) vld_q <= 1'b1;
    else if (m_axis_tready) vld_q <= 1'b0;
  end

  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = {4'd0, score_q};
  assign m_axis_tuser = rej_q;

endmodule
